// ===== rtl/lipkp_pkg.sv =====
package lipkp_pkg;

  // Field and register widths.
  localparam int KEY_W       = 8;
  localparam int OP_W        = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Input opcodes. The fourth code is ignored by the block.
  typedef enum logic [OP_W-1:0] {
    OP_KEY     = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2
  } op_t;

  // Which key of a pair is active downstream.
  typedef enum logic [1:0] {
    SEL_NONE   = 2'd0,
    SEL_FIRST  = 2'd1,
    SEL_SECOND = 2'd2
  } sel_t;

  // One result item without its framing bits.
  typedef struct packed {
    logic             act_valid;
    logic [KEY_W-1:0] key;
    logic             release_key;
  } result_t;

  // All results caused by one input item, packed from slot zero upward.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic    [CNT_W-1:0]       cnt_m1;
    logic                      pass;
  } bundle_t;

endpackage

// ===== rtl/lipkp_engine.sv =====
module lipkp_engine #(
  parameter int NUM_PAIRS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [lipkp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lipkp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          fire,
  input  logic [lipkp_pkg::OP_W-1:0]      opcode,
  input  logic [lipkp_pkg::KEY_W-1:0]     key_code,
  input  logic                          key_released,
  output lipkp_pkg::bundle_t            bundle
);
  import lipkp_pkg::*;

  localparam int PW = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;

  // Pair configuration and per-pair tracking state.
  logic [CFG_W-1:0]     pair_cfg [NUM_PAIRS];
  logic                 enabled;
  logic                 enabled_next;
  logic [NUM_PAIRS-1:0] first_held;
  logic [NUM_PAIRS-1:0] first_held_next;
  logic [NUM_PAIRS-1:0] second_held;
  logic [NUM_PAIRS-1:0] second_held_next;
  sel_t                 active [NUM_PAIRS];
  sel_t                 active_next [NUM_PAIRS];

  // Pair decode.
  logic [KEY_W-1:0]     key_a [NUM_PAIRS];
  logic [KEY_W-1:0]     key_b [NUM_PAIRS];
  logic [NUM_PAIRS-1:0] used;

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      key_a[p] = pair_cfg[p][KEY_W-1:0];
      key_b[p] = pair_cfg[p][2*KEY_W-1:KEY_W];
      used[p]  = (key_a[p] != '0) && (key_b[p] != '0) && (key_a[p] != key_b[p]);
    end
  end

  // The lowest-numbered pair that holds the key wins.
  logic          found;
  logic [PW-1:0] hit;

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (!found && used[p] && ((key_a[p] == key_code) || (key_b[p] == key_code))) begin
        found = 1'b1;
        hit   = PW'(p);
      end
    end
  end

  // Per-item decision: next state and the packed list of results.
  logic             is_first;
  logic             this_held;
  logic             other_held;
  logic [KEY_W-1:0] other_key;
  logic [KEY_W-1:0] act_key;
  sel_t             mine;
  sel_t             theirs;
  sel_t             act;
  logic [CNT_W:0]   n;

  always_comb begin
    enabled_next     = enabled;
    first_held_next  = first_held;
    second_held_next = second_held;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      active_next[p] = active[p];
    end
    bundle     = '0;
    n          = '0;

    is_first   = (key_code == key_a[hit]);
    this_held  = is_first ? first_held[hit] : second_held[hit];
    other_held = is_first ? second_held[hit] : first_held[hit];
    other_key  = is_first ? key_b[hit] : key_a[hit];
    mine       = is_first ? SEL_FIRST : SEL_SECOND;
    theirs     = is_first ? SEL_SECOND : SEL_FIRST;
    act        = active[hit];
    act_key    = (act == SEL_FIRST) ? key_a[hit] : key_b[hit];

    unique case (opcode)
      OP_ENABLE: begin
        if (!enabled) begin
          enabled_next     = 1'b1;
          first_held_next  = '0;
          second_held_next = '0;
          for (int p = 0; p < NUM_PAIRS; p++) begin
            active_next[p] = SEL_NONE;
          end
        end
      end
      OP_DISABLE: begin
        if (enabled) begin
          enabled_next     = 1'b0;
          first_held_next  = '0;
          second_held_next = '0;
          // One key-up for each active key, in pair order.
          for (int p = 0; p < NUM_PAIRS; p++) begin
            active_next[p] = SEL_NONE;
            if (active[p] == SEL_FIRST || active[p] == SEL_SECOND) begin
              bundle.res[n[CNT_W-1:0]].act_valid   = 1'b1;
              bundle.res[n[CNT_W-1:0]].key         =
                (active[p] == SEL_FIRST) ? key_a[p] : key_b[p];
              bundle.res[n[CNT_W-1:0]].release_key = 1'b1;
              n = n + 1'b1;
            end
          end
        end
      end
      OP_KEY: begin
        if (!enabled || !found) begin
          bundle.pass = 1'b1;
        end else if (!key_released) begin
          // Press: release the active partner, then press this key.
          if (!this_held) begin
            if (is_first) begin
              first_held_next[hit] = 1'b1;
            end else begin
              second_held_next[hit] = 1'b1;
            end
            if (act != mine) begin
              if (act != SEL_NONE) begin
                bundle.res[0].act_valid   = 1'b1;
                bundle.res[0].key         = act_key;
                bundle.res[0].release_key = 1'b1;
                n = n + 1'b1;
              end
              bundle.res[n[CNT_W-1:0]].act_valid   = 1'b1;
              bundle.res[n[CNT_W-1:0]].key         = key_code;
              bundle.res[n[CNT_W-1:0]].release_key = 1'b0;
              n = n + 1'b1;
              active_next[hit] = mine;
            end
          end
        end else begin
          // Release: only the active key produces actions.
          if (is_first) begin
            first_held_next[hit] = 1'b0;
          end else begin
            second_held_next[hit] = 1'b0;
          end
          if (act == mine) begin
            bundle.res[0].act_valid   = 1'b1;
            bundle.res[0].key         = key_code;
            bundle.res[0].release_key = 1'b1;
            n = n + 1'b1;
            active_next[hit] = SEL_NONE;
            if (other_held) begin
              bundle.res[1].act_valid   = 1'b1;
              bundle.res[1].key         = other_key;
              bundle.res[1].release_key = 1'b0;
              n = n + 1'b1;
              active_next[hit] = theirs;
            end
          end
        end
      end
      default: begin
      end
    endcase

    bundle.cnt_m1 = (n == '0) ? '0 : CNT_W'(n - 1'b1);
  end

  // State registers. A pair write clears that pair's tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b1;
      first_held  <= '0;
      second_held <= '0;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pair_cfg[p] <= '0;
        active[p]   <= SEL_NONE;
      end
    end else if (cfg_write_en) begin
      if (int'(cfg_index) < NUM_PAIRS) begin
        pair_cfg[cfg_index[PW-1:0]]    <= cfg_data;
        first_held[cfg_index[PW-1:0]]  <= 1'b0;
        second_held[cfg_index[PW-1:0]] <= 1'b0;
        active[cfg_index[PW-1:0]]      <= SEL_NONE;
      end
    end else if (fire) begin
      enabled     <= enabled_next;
      first_held  <= first_held_next;
      second_held <= second_held_next;
      for (int p = 0; p < NUM_PAIRS; p++) begin
        active[p] <= active_next[p];
      end
    end
  end

endmodule

// ===== rtl/last_input_priority_key_pairs.sv =====
// Opposing-key cleaner with last-input priority. Each input item is taken into
// an input register and decided against the pair state; all of its results are
// loaded at once into an output register that hands them out one per cycle
// while out_ready is high, the last one marked by last_result. An item has one
// result for an ignored, swallowed or passed-through event or for enable, up to
// two for a key event, and up to NUM_PAIRS for disable. An item waits in the
// input register while the output register holds results of the previous
// item, and a new item is taken while that item's final result is delivered;
// its first result is presented once it has passed both registers. The user
// must write pair registers only while the block is idle; the block does not
// enforce this. A write clears that pair's tracking state without any action.
module last_input_priority_key_pairs #(
  parameter int NUM_PAIRS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [lipkp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lipkp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lipkp_pkg::OP_W-1:0]      opcode,
  input  logic [lipkp_pkg::KEY_W-1:0]     key_code,
  input  logic                            key_released,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            action_valid,
  output logic [lipkp_pkg::KEY_W-1:0]     action_key,
  output logic                            action_release,
  output logic                            pass_original,
  output logic                            last_result
);
  import lipkp_pkg::*;

  // Input register.
  logic             s1_valid;
  logic [OP_W-1:0]  s1_op;
  logic [KEY_W-1:0] s1_key;
  logic             s1_rel;

  // Output register holding the remaining results of one item.
  logic                      bnd_valid;
  result_t [MAX_RESULTS-1:0] bnd_res;
  logic [CNT_W-1:0]          bnd_rem_m1;
  logic                      bnd_pass;

  bundle_t eng_bundle;
  logic    out_fire;
  logic    bnd_free;
  logic    eng_fire;

  assign out_fire = bnd_valid && out_ready;
  assign bnd_free = !bnd_valid || (out_fire && (bnd_rem_m1 == '0));
  assign eng_fire = s1_valid && bnd_free;
  assign in_ready = !s1_valid || eng_fire;

  lipkp_engine #(
    .NUM_PAIRS(NUM_PAIRS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fire         (eng_fire),
    .opcode       (s1_op),
    .key_code     (s1_key),
    .key_released (s1_rel),
    .bundle       (eng_bundle)
  );

  // Input stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (eng_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op  <= opcode;
      s1_key <= key_code;
      s1_rel <= key_released;
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_valid  <= 1'b0;
      bnd_rem_m1 <= '0;
    end else if (eng_fire) begin
      bnd_valid  <= 1'b1;
      bnd_rem_m1 <= eng_bundle.cnt_m1;
    end else if (out_fire) begin
      bnd_valid  <= (bnd_rem_m1 != '0);
      bnd_rem_m1 <= bnd_rem_m1 - 1'b1;
    end
  end

  // Output stage payload: results shift toward slot zero as they leave.
  always_ff @(posedge clk) begin
    if (eng_fire) begin
      bnd_res  <= eng_bundle.res;
      bnd_pass <= eng_bundle.pass;
    end else if (out_fire) begin
      bnd_res <= bnd_res >> $bits(result_t);
    end
  end

  assign out_valid      = bnd_valid;
  assign action_valid   = bnd_res[0].act_valid;
  assign action_key     = bnd_res[0].key;
  assign action_release = bnd_res[0].release_key;
  assign pass_original  = bnd_pass;
  assign last_result    = (bnd_rem_m1 == '0);

  // Only the final result of an item may be empty.
  a_inner_has_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> action_valid)
    else $error("non-final result carries no action");

  // A passed-through event is a single result with no action.
  a_pass_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && pass_original |-> last_result && !action_valid)
    else $error("pass-through result is not a lone empty result");

  // After a non-final result leaves, the rest of the item follows.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=> out_valid)
    else $error("results of an item were cut short");

endmodule
